// File: hdl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Types, codes and constants shared by the line follower PD controller.
// ----------------------------------------------------------------------------
package lfpd_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CRUISE     = 3'd0,
		REG_PROP_GAIN  = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_ALPHA      = 3'd3,
		REG_TIMEOUT    = 3'd4
	} reg_idx_t;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [4:0] RST_CRUISE     = 5'd8;
	localparam logic [3:0] RST_PROP_GAIN  = 4'd4;
	localparam logic [3:0] RST_DERIV_GAIN = 4'd3;
	localparam logic [7:0] RST_ALPHA      = 8'd180;
	localparam logic [9:0] RST_TIMEOUT    = 10'd100;

	localparam logic [4:0] SENS_ALL  = 5'h1F;
	localparam logic [4:0] SENS_NONE = 5'h00;
	localparam logic [9:0] LOST_MAX  = 10'h3FF;
	localparam logic [7:0] DIV10_RECIP = 8'd205;  // x/10 == (x*205)>>11 for x < 1024
	localparam int DIV10_SHIFT = 11;
	localparam logic [11:0] DUTY_MAX = 12'd4095;

	// internal speed width, holds +/-127 and base +/- turn
	localparam int SPD_W = 9;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 48;

	// output word layout
	localparam int OFS_LSPD   = 0;
	localparam int OFS_RSPD   = 6;
	localparam int OFS_LDIR   = 12;
	localparam int OFS_RDIR   = 14;
	localparam int OFS_LDUTY  = 16;
	localparam int OFS_RDUTY  = 28;
	localparam int OFS_HALTED = 40;

	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_FWD = 2'd1,
		DIR_REV = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		SIGN_ZERO = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_FILT,
		ST_GAIN,
		ST_SCALE,
		ST_MIX,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [4:0] cruise_spd;
		logic [3:0] prop_gain;
		logic [3:0] deriv_gain;
		logic [7:0] alpha;
		logic [9:0] lost_timeout;
	} cfg_t;

	typedef struct packed {
		logic ld_in;
		logic decode;
		logic mul;
		logic filt;
		logic gain;
		logic scale;
		logic mix;
		logic out_wr;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// truncated mean of the active sensor weights
	function automatic logic signed [5:0] err_lut(input logic [4:0] s);
		logic signed [5:0] e;
		case (s)
			5'd1:  e = -6'sd20;
			5'd2:  e = -6'sd10;
			5'd3:  e = -6'sd15;
			5'd5:  e = -6'sd10;
			5'd6:  e = -6'sd5;
			5'd7:  e = -6'sd10;
			5'd8:  e = 6'sd10;
			5'd9:  e = -6'sd5;
			5'd11: e = -6'sd6;
			5'd12: e = 6'sd5;
			5'd13: e = -6'sd3;
			5'd15: e = -6'sd5;
			5'd16: e = 6'sd20;
			5'd18: e = 6'sd5;
			5'd19: e = -6'sd3;
			5'd20: e = 6'sd10;
			5'd22: e = 6'sd3;
			5'd23: e = -6'sd2;
			5'd24: e = 6'sd15;
			5'd25: e = 6'sd3;
			5'd26: e = 6'sd6;
			5'd28: e = 6'sd10;
			5'd29: e = 6'sd2;
			5'd30: e = 6'sd5;
			default: e = 6'sd0;
		endcase
		return e;
	endfunction

endpackage

// File: hdl/lfpd_ctrl.sv
// ----------------------------------------------------------------------------
// lfpd_ctrl
// Sequencer: steps one sensor word through the datapath states.
// ----------------------------------------------------------------------------
module lfpd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  lfpd_pkg::status_t st,
	output lfpd_pkg::cmd_t    cmd
);
	import lfpd_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_n = ST_DECODE;
			ST_DECODE: state_n = ST_MUL;
			ST_MUL:    state_n = ST_FILT;
			ST_FILT:   state_n = ST_GAIN;
			ST_GAIN:   state_n = ST_SCALE;
			ST_SCALE:  state_n = ST_MIX;
			ST_MIX:    state_n = ST_OUT;
			ST_OUT:    if (st.out_free) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.ld_in = s_axis_tvalid;
			end
			ST_DECODE: cmd.decode = 1'b1;
			ST_MUL:    cmd.mul = 1'b1;
			ST_FILT:   cmd.filt = 1'b1;
			ST_GAIN:   cmd.gain = 1'b1;
			ST_SCALE:  cmd.scale = 1'b1;
			ST_MIX:    cmd.mix = 1'b1;
			ST_OUT:    cmd.out_wr = st.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

// File: hdl/lfpd_datapath.sv
// ----------------------------------------------------------------------------
// lfpd_datapath
// Error decode, derivative filter, PD gains, wheel mix, duty and output word.
// ----------------------------------------------------------------------------
module lfpd_datapath #(
	parameter int DUTY_FULL_SCALE = 4095,
	parameter int SPEED_LIMIT = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfpd_pkg::cfg_t                     cfg,
	input  lfpd_pkg::cmd_t                     cmd,
	output lfpd_pkg::status_t                  st,
	input  logic [lfpd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lfpd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import lfpd_pkg::*;

	localparam int MAG_W = $clog2(SPEED_LIMIT + 1);
	localparam logic signed [SPD_W-1:0] LIM_P = SPD_W'(SPEED_LIMIT);
	localparam logic signed [SPD_W-1:0] LIM_N = -SPD_W'(SPEED_LIMIT);

	// duty per speed magnitude, built at elaboration
	logic [11:0] duty_lut [SPEED_LIMIT+1];
	for (genvar g = 0; g <= SPEED_LIMIT; g++) begin : g_duty
		localparam longint DV = longint'(g) * DUTY_FULL_SCALE / SPEED_LIMIT;
		assign duty_lut[g] = (DV > 4095) ? DUTY_MAX : 12'(DV);
	end

	function automatic logic signed [SPD_W-1:0] clamp(input logic signed [SPD_W-1:0] v);
		if (v < LIM_N) return LIM_N;
		if (v > LIM_P) return LIM_P;
		return v;
	endfunction

	// state kept across words
	logic signed [5:0] prev_err_q;
	logic signed [6:0] sd_q;
	sign_t             last_sign_q;
	logic [9:0]        lost_cnt_q;
	logic              halt_q;

	// per-word working registers
	logic [4:0]         sens_q;
	logic signed [5:0]  err_q;
	logic signed [6:0]  raw_q;
	logic signed [15:0] prod_a_q;
	logic signed [16:0] prod_b_q;
	logic signed [6:0]  sd_new_q;
	logic signed [9:0]  pg_prod_q;
	logic signed [10:0] dg_prod_q;
	logic [15:0]        pm_q;
	logic [16:0]        dm_q;
	logic               p_neg_q, d_neg_q;
	logic signed [SPD_W-1:0] left_q, right_q;

	logic                    m_valid_q;
	logic [OUT_DATA_W-1:0]   m_data_q;

	logic signed [5:0]  err_w;
	logic signed [17:0] fsum_w, fshr_w, fadj_w;
	logic signed [9:0]  pmag_w;
	logic signed [10:0] dmag_w;
	logic signed [SPD_W-1:0] turn_w, base_w, left_w, right_w;
	logic [9:0]  lost_inc_w;
	logic        halt_now_w;
	logic signed [SPD_W-1:0] lmag_w, rmag_w;
	dir_t        ldir_w, rdir_w;

	assign err_w = err_lut(sens_q);

	// truncate-toward-zero divide by 256
	assign fsum_w = {{2{prod_a_q[15]}}, prod_a_q} + {prod_b_q[16], prod_b_q};
	assign fshr_w = fsum_w >>> 8;
	assign fadj_w = (fsum_w[17] && (fsum_w[7:0] != 8'd0)) ? fshr_w + 18'sd1 : fshr_w;

	assign pmag_w = pg_prod_q[9] ? -pg_prod_q : pg_prod_q;
	assign dmag_w = dg_prod_q[10] ? -dg_prod_q : dg_prod_q;

	always_comb begin
		logic signed [SPD_W-1:0] pq, dq;
		pq = SPD_W'(pm_q[15:DIV10_SHIFT]);
		dq = SPD_W'(dm_q[16:DIV10_SHIFT]);
		if (p_neg_q) pq = -pq;
		if (d_neg_q) dq = -dq;
		turn_w = pq + dq;
	end

	assign base_w     = SPD_W'(cfg.cruise_spd);
	assign lost_inc_w = (lost_cnt_q == LOST_MAX) ? lost_cnt_q : lost_cnt_q + 10'd1;
	assign halt_now_w = (lost_inc_w >= cfg.lost_timeout);

	always_comb begin
		left_w  = '0;
		right_w = '0;
		if (!halt_q) begin
			if (sens_q == SENS_ALL) begin
				left_w  = clamp(base_w);
				right_w = clamp(base_w);
			end else if (sens_q != SENS_NONE) begin
				left_w  = clamp(base_w + turn_w);
				right_w = clamp(base_w - turn_w);
			end else if (!halt_now_w) begin
				// pivot toward the side the line was last seen on
				case (last_sign_q)
					SIGN_NEG: begin
						left_w  = clamp(-SPD_W'(5));
						right_w = clamp(SPD_W'(8));
					end
					SIGN_POS: begin
						left_w  = clamp(SPD_W'(8));
						right_w = clamp(-SPD_W'(5));
					end
					default: begin
						left_w  = clamp(SPD_W'(4));
						right_w = clamp(SPD_W'(4));
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			sd_q        <= '0;
			last_sign_q <= SIGN_ZERO;
			lost_cnt_q  <= '0;
			halt_q      <= 1'b0;
		end else if (cmd.mix && !halt_q) begin
			if (sens_q == SENS_ALL) begin
				prev_err_q <= '0;
				sd_q       <= '0;
				lost_cnt_q <= '0;
			end else if (sens_q != SENS_NONE) begin
				prev_err_q <= err_q;
				sd_q       <= sd_new_q;
				lost_cnt_q <= '0;
				if (err_q > 6'sd0)
					last_sign_q <= SIGN_POS;
				else if (err_q < 6'sd0)
					last_sign_q <= SIGN_NEG;
				else
					last_sign_q <= SIGN_ZERO;
			end else begin
				lost_cnt_q <= lost_inc_w;
				if (halt_now_w) halt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) sens_q <= s_axis_tdata[4:0];
		if (cmd.decode) begin
			err_q <= err_w;
			raw_q <= {err_w[5], err_w} - {prev_err_q[5], prev_err_q};
		end
		if (cmd.mul) begin
			prod_a_q <= $signed({1'b0, cfg.alpha}) * sd_q;
			prod_b_q <= $signed({1'b0, 9'd256 - {1'b0, cfg.alpha}}) * raw_q;
		end
		if (cmd.filt) sd_new_q <= fadj_w[6:0];
		if (cmd.gain) begin
			pg_prod_q <= $signed({1'b0, cfg.prop_gain}) * err_q;
			dg_prod_q <= $signed({1'b0, cfg.deriv_gain}) * sd_new_q;
		end
		if (cmd.scale) begin
			pm_q    <= 16'(pmag_w[8:0]) * 16'(DIV10_RECIP);
			dm_q    <= 17'(dmag_w[9:0]) * 17'(DIV10_RECIP);
			p_neg_q <= pg_prod_q[9];
			d_neg_q <= dg_prod_q[10];
		end
		if (cmd.mix) begin
			left_q  <= left_w;
			right_q <= right_w;
		end
	end

	// output stage
	assign lmag_w = left_q[SPD_W-1] ? -left_q : left_q;
	assign rmag_w = right_q[SPD_W-1] ? -right_q : right_q;
	assign ldir_w = (left_q > 0) ? DIR_FWD : ((left_q < 0) ? DIR_REV : DIR_OFF);
	assign rdir_w = (right_q > 0) ? DIR_FWD : ((right_q < 0) ? DIR_REV : DIR_OFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_wr) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			m_data_q <= {7'd0, halt_q,
				duty_lut[rmag_w[MAG_W-1:0]], duty_lut[lmag_w[MAG_W-1:0]],
				rdir_w, ldir_w, right_q[5:0], left_q[5:0]};
		end
	end

	assign st.out_free   = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// File: hdl/line_follow_pd_controller_core.sv
// ----------------------------------------------------------------------------
// line_follow_pd_controller_core
// The sequencer steps each accepted sensor word through decode, filter multiply,
// filter divide, gain, divide-by-ten and mix, then writes it to the output register,
// which raises m_axis_tvalid. A new word is taken only once the last one is written.
// A finished word waits in the output register while the next one is taken in.
// Reset (arst_n low) clears filter state, lost count, halt and loads default config.
// ----------------------------------------------------------------------------
module line_follow_pd_controller_core #(
	parameter int DUTY_FULL_SCALE = 4095,
	parameter int SPEED_LIMIT = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [lfpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [4:0] sensors
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [5:0] left_spd, [11:6] right_spd, [13:12] left_dir, [15:14] right_dir,
	// [27:16] left_duty, [39:28] right_duty, [40] halted
	output logic [lfpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [lfpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import lfpd_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cruise_spd   <= RST_CRUISE;
			cfg_q.prop_gain    <= RST_PROP_GAIN;
			cfg_q.deriv_gain   <= RST_DERIV_GAIN;
			cfg_q.alpha        <= RST_ALPHA;
			cfg_q.lost_timeout <= RST_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CRUISE:     cfg_q.cruise_spd   <= cfg_wdata[4:0];
				REG_PROP_GAIN:  cfg_q.prop_gain    <= cfg_wdata[3:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain   <= cfg_wdata[3:0];
				REG_ALPHA:      cfg_q.alpha        <= cfg_wdata[7:0];
				REG_TIMEOUT:    cfg_q.lost_timeout <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	lfpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.st           (st),
		.cmd          (cmd)
	);

	lfpd_datapath #(
		.DUTY_FULL_SCALE(DUTY_FULL_SCALE),
		.SPEED_LIMIT    (SPEED_LIMIT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.st           (st),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

// File: hdl/lfpd_checker.sv
// ----------------------------------------------------------------------------
// lfpd_props
// Port-level checks on the controller output stream.
// ----------------------------------------------------------------------------
module lfpd_props (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lfpd_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import lfpd_pkg::*;

	logic seen_halt_q;
	logic halted_w;

	assign halted_w = m_axis_tdata[OFS_HALTED];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && halted_w) begin
			seen_halt_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// halt is sticky until reset
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && seen_halt_q |-> halted_w)
		else $error("halt cleared without reset");

	a_halt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && halted_w |-> m_axis_tdata[OFS_HALTED-1:0] == '0)
		else $error("halted word drives the wheels");

	a_dir_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			((m_axis_tdata[OFS_RSPD-1:OFS_LSPD] == 6'd0) ==
			 (m_axis_tdata[OFS_RDIR-1:OFS_LDIR] == DIR_OFF)))
		else $error("left direction disagrees with left speed");

endmodule

bind line_follow_pd_controller_core lfpd_props u_lfpd_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
